FILE: hdl/s2l_pkg.sv
package s2l_pkg;

    localparam int LIN_W  = 31;   // Q30 linear light, 0..1.0
    localparam int ROOT_W = 31;   // Q30 Lab f input and output

    localparam longint unsigned ONE30  = 64'd1 << 30;
    localparam longint unsigned HALF30 = 64'd1 << 29;

    // Register stage map of the pipeline
    localparam int ST_LIN   = 0;
    localparam int ST_PROD  = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_DIV1  = 3;
    localparam int ST_WN    = 6;
    localparam int ST_DIV2  = 7;
    localparam int ST_ROOT  = 10;
    localparam int ST_LINF  = 10;
    localparam int ST_DIV3  = 11;
    localparam int ST_SEL   = 72;
    localparam int ST_MUL   = 73;
    localparam int ST_OUT   = 74;
    localparam int STG_N    = 75;

    typedef logic [255:0][LIN_W-1:0] lin_tab_t;

    // sRGB decoding curve for one 8-bit code, Q30
    function automatic logic [LIN_W-1:0] lin_calc(input logic [7:0] code);
        longint unsigned c;
        longint unsigned s;
        longint unsigned q;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        int i;
        c = 64'(code);
        if (c <= 64'd10) begin
            return LIN_W'((c * 64'd100 * ONE30 + 64'd164730) / 64'd329460);
        end
        s = ((64'd1000 * c + 64'd14025) * ONE30 + 64'd134512) / 64'd269025;
        q = (s * s + HALF30) >> 30;
        // q^(1/5) by bisection, truncated fixed-point powers
        lo = 64'd0;
        hi = ONE30 + 64'd1;
        while (hi - lo > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            p = mid;
            for (i = 1; i < 5; i++) begin
                p = (p * mid) >> 30;
            end
            if (p <= q) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return LIN_W'((q * lo + HALF30) >> 30);
    endfunction

    function automatic lin_tab_t lin_table();
        lin_tab_t tab;
        int k;
        for (k = 0; k < 256; k++) begin
            tab[k] = lin_calc(8'(k));
        end
        return tab;
    endfunction

    localparam lin_tab_t LIN_TAB = lin_table();

endpackage

FILE: hdl/srgb_to_cielab_converter_unit.sv
// sRGB to CIE XYZ / CIELAB (D65) pixel converter. Takes one 8-bit RGB pixel
// per clock on the s_ channel and returns XYZ (unsigned, XYZ_FRAC_BITS fraction
// bits, saturating) together with L, a, b in hundredths on the m_ channel.
// Throughput is one pixel per cycle; most of the pipeline is the Lab cube
// root, which resolves one bit per two stages over 31 bits. Stalls on m_ready
// freeze only the stages that are full, so empty stages keep taking pixels.
// XYZ_FRAC_BITS must stay within 12..24; the unit does not check it.
module srgb_to_cielab_converter_unit import s2l_pkg::*; #(
    parameter int XYZ_FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_red,
    input  logic [7:0]         s_green,
    input  logic [7:0]         s_blue,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_xyz_x,
    output logic [16:0]        m_xyz_y,
    output logic [16:0]        m_xyz_z,
    output logic [13:0]        m_lightness,
    output logic signed [14:0] m_green_red,
    output logic signed [14:0] m_blue_yellow
);

    localparam int SH = 30 - XYZ_FRAC_BITS;
    localparam int MAT_W = 54;
    localparam logic [23:0] MAT [3][3] = '{
        '{24'd4124564, 24'd3575761, 24'd1804375},
        '{24'd2126729, 24'd7151522, 24'd721750},
        '{24'd193339,  24'd1191920, 24'd9503041}
    };
    localparam logic [MAT_W-1:0] MAT_RND   = MAT_W'(5000000);
    localparam logic [47:0]      WX_MUL    = 48'd100000;
    localparam logic [47:0]      WX_RND    = 48'd47523;
    localparam logic [47:0]      WZ_RND    = 48'd54441;
    localparam logic [46:0]      LIN_MUL   = 47'd24389;
    localparam logic [46:0]      LIN_THR   = 47'd216 << 30;
    localparam logic [46:0]      LIN_OFS   = (47'd432 << 30) + 47'd1566;
    localparam logic signed [49:0] K_L     = 50'sd11600;
    localparam logic signed [49:0] K_LOFS  = 50'sd1717986918400;
    localparam logic signed [49:0] K_A     = 50'sd50000;
    localparam logic signed [49:0] K_B     = 50'sd20000;
    localparam logic signed [49:0] HALF_R  = 50'sd536870912;
    localparam logic signed [49:0] L_MAX   = 50'sd10000;
    localparam logic signed [49:0] AB_MAX  = 50'sd12800;
    localparam logic signed [49:0] AB_MIN  = -50'sd12800;

    logic [STG_N-1:0] stg_en;

    s2l_pipe_ctl u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .en      (stg_en)
    );

    // ---- linearize, matrix ----
    logic [7:0]        code    [3];
    logic [LIN_W-1:0]  lin_reg [3];
    logic [MAT_W-1:0]  prod_reg [3][3];
    logic [MAT_W-1:0]  sum_reg [3];
    logic [30:0]       xyz_q   [3];

    assign code[0] = s_red;
    assign code[1] = s_green;
    assign code[2] = s_blue;

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            if (stg_en[ST_LIN]) begin
                lin_reg[c] <= LIN_TAB[code[c]];
            end
            if (stg_en[ST_PROD]) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[c][k] <= MAT_W'(lin_reg[k]) * MAT_W'(MAT[c][k]);
                end
            end
            if (stg_en[ST_SUM]) begin
                sum_reg[c] <= prod_reg[c][0] + prod_reg[c][1] + prod_reg[c][2] + MAT_RND;
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_mat_div
        s2l_cdiv #(
            .DIVISOR (10000000),
            .NUM_W   (MAT_W),
            .QUO_W   (31),
            .BASE    (ST_DIV1)
        ) u_div (
            .aclk (aclk),
            .en   (stg_en),
            .num  (sum_reg[c]),
            .quo  (xyz_q[c])
        );
    end

    // ---- XYZ output rounding, white scaling ----
    function automatic logic [16:0] xyz_round(input logic [30:0] v, input logic [16:0] maxv);
        logic [31:0] acc;
        acc = ({1'b0, v} + (32'd1 << (SH - 1))) >> SH;
        return (acc > {15'd0, maxv}) ? maxv : acc[16:0];
    endfunction

    logic [16:0] xo_next;
    logic [16:0] yo_next;
    logic [16:0] zo_next;
    logic [49:0] xyz_o_reg;
    logic [49:0] xyz_o_dly;
    logic [47:0] nx_reg;
    logic [47:0] nz_reg;
    logic [30:0] y_w_reg;
    logic [30:0] t_chan [3];

    always_comb begin
        xo_next = xyz_round(xyz_q[0], 17'h0FFFF);
        yo_next = xyz_round(xyz_q[1], 17'h1FFFF);
        zo_next = xyz_round(xyz_q[2], 17'h1FFFF);
    end

    always_ff @(posedge aclk) begin
        if (stg_en[ST_WN]) begin
            xyz_o_reg <= {xo_next[15:0], yo_next, zo_next};
            nx_reg    <= 48'(xyz_q[0]) * WX_MUL + WX_RND;
            nz_reg    <= 48'(xyz_q[2]) * WX_MUL + WZ_RND;
            y_w_reg   <= xyz_q[1];
        end
    end

    s2l_dly #(.WIDTH(50), .BASE(ST_WN + 1), .LEN(ST_OUT - ST_WN)) u_xyz_dly (
        .aclk (aclk),
        .en   (stg_en),
        .din  (xyz_o_reg),
        .dout (xyz_o_dly)
    );

    s2l_cdiv #(.DIVISOR(95047), .NUM_W(48), .QUO_W(31), .BASE(ST_DIV2)) u_wx_div (
        .aclk (aclk),
        .en   (stg_en),
        .num  (nx_reg),
        .quo  (t_chan[0])
    );

    s2l_cdiv #(.DIVISOR(108883), .NUM_W(48), .QUO_W(31), .BASE(ST_DIV2)) u_wz_div (
        .aclk (aclk),
        .en   (stg_en),
        .num  (nz_reg),
        .quo  (t_chan[2])
    );

    s2l_dly #(.WIDTH(31), .BASE(ST_DIV2), .LEN(ST_ROOT - ST_DIV2)) u_y_dly (
        .aclk (aclk),
        .en   (stg_en),
        .din  (y_w_reg),
        .dout (t_chan[1])
    );

    // ---- Lab f: cube root and linear segment in parallel ----
    logic [46:0] ln_prod  [3];
    logic        big_reg  [3];
    logic [39:0] nlin_reg [3];
    logic [30:0] flin_q   [3];
    logic [30:0] flin_d   [3];
    logic        big_d    [3];
    logic [30:0] root_q   [3];
    logic [30:0] f_sel    [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ln_prod[c] = 47'(t_chan[c]) * LIN_MUL;
            f_sel[c]   = big_d[c] ? root_q[c] : flin_d[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[ST_LINF]) begin
            for (int c = 0; c < 3; c++) begin
                big_reg[c]  <= ln_prod[c] > LIN_THR;
                nlin_reg[c] <= 40'(ln_prod[c] + LIN_OFS);
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_curve
        s2l_cbrt #(.BASE(ST_ROOT)) u_cbrt (
            .aclk (aclk),
            .en   (stg_en),
            .rad  (t_chan[c]),
            .root (root_q[c])
        );

        s2l_cdiv #(.DIVISOR(3132), .NUM_W(40), .QUO_W(31), .BASE(ST_DIV3)) u_lin_div (
            .aclk (aclk),
            .en   (stg_en),
            .num  (nlin_reg[c]),
            .quo  (flin_q[c])
        );

        s2l_dly #(.WIDTH(31), .BASE(ST_DIV3 + 3), .LEN(ST_SEL - ST_DIV3 - 3)) u_flin_dly (
            .aclk (aclk),
            .en   (stg_en),
            .din  (flin_q[c]),
            .dout (flin_d[c])
        );

        s2l_dly #(.WIDTH(1), .BASE(ST_LINF + 1), .LEN(ST_SEL - ST_LINF - 1)) u_big_dly (
            .aclk (aclk),
            .en   (stg_en),
            .din  (big_reg[c]),
            .dout (big_d[c])
        );
    end

    // ---- L, a, b ----
    logic [30:0]        fy_reg;
    logic signed [31:0] dxy_reg;
    logic signed [31:0] dyz_reg;
    logic signed [49:0] lv_reg;
    logic signed [49:0] av_reg;
    logic signed [49:0] bv_reg;
    logic signed [49:0] lv_sh;
    logic signed [49:0] av_sh;
    logic signed [49:0] bv_sh;
    logic [13:0]        light_next;
    logic signed [14:0] ga_next;
    logic signed [14:0] bb_next;
    logic [13:0]        light_reg;
    logic signed [14:0] ga_reg;
    logic signed [14:0] bb_reg;

    always_comb begin
        lv_sh = (lv_reg + HALF_R) >>> 30;
        av_sh = (av_reg + HALF_R) >>> 30;
        bv_sh = (bv_reg + HALF_R) >>> 30;
        if (lv_sh < 50'sd0) begin
            light_next = '0;
        end else if (lv_sh > L_MAX) begin
            light_next = 14'd10000;
        end else begin
            light_next = lv_sh[13:0];
        end
        if (av_sh < AB_MIN) begin
            ga_next = -15'sd12800;
        end else if (av_sh > AB_MAX) begin
            ga_next = 15'sd12800;
        end else begin
            ga_next = av_sh[14:0];
        end
        if (bv_sh < AB_MIN) begin
            bb_next = -15'sd12800;
        end else if (bv_sh > AB_MAX) begin
            bb_next = 15'sd12800;
        end else begin
            bb_next = bv_sh[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[ST_SEL]) begin
            fy_reg  <= f_sel[1];
            dxy_reg <= $signed({1'b0, f_sel[0]}) - $signed({1'b0, f_sel[1]});
            dyz_reg <= $signed({1'b0, f_sel[1]}) - $signed({1'b0, f_sel[2]});
        end
        if (stg_en[ST_MUL]) begin
            lv_reg <= 50'($signed({1'b0, fy_reg})) * K_L - K_LOFS;
            av_reg <= 50'(dxy_reg) * K_A;
            bv_reg <= 50'(dyz_reg) * K_B;
        end
        if (stg_en[ST_OUT]) begin
            light_reg <= light_next;
            ga_reg    <= ga_next;
            bb_reg    <= bb_next;
        end
    end

    assign m_xyz_x       = xyz_o_dly[49:34];
    assign m_xyz_y       = xyz_o_dly[33:17];
    assign m_xyz_z       = xyz_o_dly[16:0];
    assign m_lightness   = light_reg;
    assign m_green_red   = ga_reg;
    assign m_blue_yellow = bb_reg;

    a_light_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_lightness <= 14'd10000)
        else $error("lightness out of range");

    a_ab_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_green_red >= -15'sd12800 && m_green_red <= 15'sd12800 &&
                     m_blue_yellow >= -15'sd12800 && m_blue_yellow <= 15'sd12800))
        else $error("a or b out of range");

    a_empty_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("pipeline refused a request with an empty output stage");

endmodule

FILE: hdl/s2l_dly.sv
module s2l_dly import s2l_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int BASE  = 0,
    parameter int LEN   = 1
) (
    input  logic             aclk,
    input  logic [STG_N-1:0] en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [LEN];

    always_ff @(posedge aclk) begin
        if (en[BASE]) begin
            tap_reg[0] <= din;
        end
        for (int i = 1; i < LEN; i++) begin
            if (en[BASE + i]) begin
                tap_reg[i] <= tap_reg[i - 1];
            end
        end
    end

    assign dout = tap_reg[LEN - 1];

endmodule

FILE: hdl/s2l_cdiv.sv
module s2l_cdiv import s2l_pkg::*; #(
    parameter longint unsigned DIVISOR = 10,
    parameter int NUM_W = 40,
    parameter int QUO_W = 31,
    parameter int BASE  = 0
) (
    input  logic             aclk,
    input  logic [STG_N-1:0] en,
    input  logic [NUM_W-1:0] num,
    output logic [QUO_W-1:0] quo
);

    // Estimate from the top 32 numerator bits, then fix up by at most two.
    localparam int SHIFT = NUM_W - 32;
    localparam int DIV_W = $clog2(DIVISOR + 1);
    localparam longint unsigned RECIP = (64'd1 << (SHIFT + 32)) / DIVISOR;
    localparam logic [31:0]      RECIP_V = 32'(RECIP);
    localparam logic [DIV_W-1:0] DIV_V   = DIV_W'(DIVISOR);
    localparam logic [NUM_W-1:0] DIV1_N  = NUM_W'(DIVISOR);
    localparam logic [NUM_W-1:0] DIV2_N  = NUM_W'(2 * DIVISOR);

    logic [NUM_W-1:0]  num_a_reg;
    logic [NUM_W-1:0]  num_b_reg;
    logic [63:0]       est_reg;
    logic [31:0]       q0_reg;
    logic [31+DIV_W:0] qd_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [31:0]       q0_next;
    logic [NUM_W-1:0]  rem;
    logic [31:0]       quo_next;

    assign q0_next = est_reg[63:32];

    always_comb begin
        rem = num_b_reg - qd_reg[NUM_W-1:0];
        if (rem >= DIV2_N) begin
            quo_next = q0_reg + 32'd2;
        end else if (rem >= DIV1_N) begin
            quo_next = q0_reg + 32'd1;
        end else begin
            quo_next = q0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[BASE]) begin
            num_a_reg <= num;
            est_reg   <= 64'(num[NUM_W-1:SHIFT]) * 64'(RECIP_V);
        end
        if (en[BASE + 1]) begin
            num_b_reg <= num_a_reg;
            q0_reg    <= q0_next;
            qd_reg    <= q0_next * DIV_V;
        end
        if (en[BASE + 2]) begin
            quo_reg <= quo_next[QUO_W-1:0];
        end
    end

    assign quo = quo_reg;

endmodule

FILE: hdl/s2l_cbrt.sv
module s2l_cbrt import s2l_pkg::*; #(
    parameter int BASE = 0
) (
    input  logic              aclk,
    input  logic [STG_N-1:0]  en,
    input  logic [ROOT_W-1:0] rad,
    output logic [ROOT_W-1:0] root
);

    // One result bit per step, MSB first. r*r is kept exactly and updated
    // with shifts; each step spends one multiply on the truncated cube.
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int PROD_W = SQ_W + 1;

    logic [ROOT_W-1:0] rad_a_reg [ROOT_W];
    logic [ROOT_W-1:0] r_a_reg   [ROOT_W];
    logic [SQ_W-1:0]   sq_a_reg  [ROOT_W];
    logic [SQ_W-1:0]   sqt_a_reg [ROOT_W];
    logic [ROOT_W-1:0] rad_b_reg [ROOT_W];
    logic [ROOT_W-1:0] r_b_reg   [ROOT_W];
    logic [SQ_W-1:0]   sq_b_reg  [ROOT_W];

    logic [ROOT_W-1:0] rad_in   [ROOT_W];
    logic [ROOT_W-1:0] r_in     [ROOT_W];
    logic [SQ_W-1:0]   sq_in    [ROOT_W];
    logic [SQ_W-1:0]   sqt_next [ROOT_W];
    logic [ROOT_W-1:0] rt       [ROOT_W];
    logic [PROD_W-1:0] prod     [ROOT_W];
    logic              fit      [ROOT_W];

    always_comb begin
        rad_in[0] = rad;
        r_in[0]   = '0;
        sq_in[0]  = '0;
        for (int j = 1; j < ROOT_W; j++) begin
            rad_in[j] = rad_b_reg[j - 1];
            r_in[j]   = r_b_reg[j - 1];
            sq_in[j]  = sq_b_reg[j - 1];
        end
        for (int j = 0; j < ROOT_W; j++) begin
            // (r + 2^k)^2 = r^2 + r*2^(k+1) + 2^(2k)
            sqt_next[j] = sq_in[j] + (SQ_W'(r_in[j]) << (ROOT_W - j))
                        + (SQ_W'(1) << (2 * (ROOT_W - 1 - j)));
            rt[j]   = r_a_reg[j] | (ROOT_W'(1) << (ROOT_W - 1 - j));
            prod[j] = PROD_W'(sqt_a_reg[j][SQ_W-1:30]) * PROD_W'(rt[j]);
            fit[j]  = prod[j][PROD_W-1:30] <= (PROD_W - 30)'(rad_a_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < ROOT_W; j++) begin
            if (en[BASE + 2 * j]) begin
                rad_a_reg[j] <= rad_in[j];
                r_a_reg[j]   <= r_in[j];
                sq_a_reg[j]  <= sq_in[j];
                sqt_a_reg[j] <= sqt_next[j];
            end
            if (en[BASE + 2 * j + 1]) begin
                rad_b_reg[j] <= rad_a_reg[j];
                r_b_reg[j]   <= fit[j] ? rt[j] : r_a_reg[j];
                sq_b_reg[j]  <= fit[j] ? sqt_a_reg[j] : sq_a_reg[j];
            end
        end
    end

    assign root = r_b_reg[ROOT_W - 1];

endmodule

FILE: hdl/s2l_pipe_ctl.sv
module s2l_pipe_ctl import s2l_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             m_ready,
    output logic             s_ready,
    output logic             m_valid,
    output logic [STG_N-1:0] en
);

    localparam logic [STG_N-1:0] ALL_ONES = {STG_N{1'b1}};

    logic [STG_N-1:0] vld_reg;
    logic [STG_N-1:0] vld_next;

    // A stage moves when the output drains or some stage at or after it
    // holds a bubble.
    always_comb begin
        for (int i = 0; i < STG_N; i++) begin
            en[i] = m_ready || !(&(vld_reg | ~(ALL_ONES << i)));
        end
        vld_next[0] = en[0] ? s_valid : vld_reg[0];
        for (int i = 1; i < STG_N; i++) begin
            vld_next[i] = en[i] ? vld_reg[i - 1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[STG_N - 1];

endmodule

FILE: tb/tb_top.sv
`default_nettype none

typedef struct {
    logic [15:0]        x;
    logic [16:0]        y;
    logic [16:0]        z;
    logic [13:0]        lum;
    logic signed [14:0] ga;
    logic signed [14:0] by;
} lab_px_t;

class lab_scoreboard;
    lab_px_t pending[$];
    int      errors;
    longint unsigned lin_lut[256];

    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint unsigned QH  = 64'd1 << 29;

    function new();
        int k;
        errors = 0;
        for (k = 0; k < 256; k++) lin_lut[k] = decode_gamma(k);
    endfunction

    // truncated fixed-point power, Q30
    function longint unsigned qpow(longint unsigned v, int n);
        longint unsigned acc;
        int i;
        acc = v;
        for (i = 1; i < n; i++) acc = (acc * v) >> 30;
        return acc;
    endfunction

    function longint unsigned qroot(longint unsigned t, int n, longint unsigned hi);
        longint unsigned lo;
        longint unsigned mid;
        lo = 0;
        while (hi - lo > 1) begin
            mid = lo + ((hi - lo) >> 1);
            if (qpow(mid, n) <= t) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function longint unsigned decode_gamma(longint unsigned c);
        longint unsigned s;
        longint unsigned q;
        longint unsigned rt;
        if (c <= 10) return (c * 100 * Q30 + 164730) / 329460;
        s = ((1000 * c + 14025) * Q30 + 134512) / 269025;
        q = (s * s + QH) >> 30;
        rt = qroot(q, 5, Q30 + 1);
        return (q * rt + QH) >> 30;
    endfunction

    function longint lab_f(longint unsigned t);
        if (t * 24389 > 216 * Q30) return longint'(qroot(t, 3, 2 * Q30));
        return longint'((t * 24389 + 432 * Q30 + 1566) / 3132);
    endfunction

    function longint rnd30(longint v);
        return (v + longint'(QH)) >>> 30;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint unsigned to_xyz(longint unsigned v, longint unsigned maxv);
        longint unsigned r;
        r = (v + (64'd1 << 13)) >> 14;
        return r > maxv ? maxv : r;
    endfunction

    function void note_pixel(logic [7:0] red, logic [7:0] grn, logic [7:0] blu);
        longint unsigned r, g, b, x, y, z, tx, tz;
        longint fx, fy, fz, lv, av, bv;
        lab_px_t e;
        r = lin_lut[red];
        g = lin_lut[grn];
        b = lin_lut[blu];
        x = (r * 4124564 + g * 3575761 + b * 1804375 + 5000000) / 10000000;
        y = (r * 2126729 + g * 7151522 + b * 721750 + 5000000) / 10000000;
        z = (r * 193339 + g * 1191920 + b * 9503041 + 5000000) / 10000000;
        tx = (x * 100000 + 47523) / 95047;
        tz = (z * 100000 + 54441) / 108883;
        fx = lab_f(tx);
        fy = lab_f(y);
        fz = lab_f(tz);
        lv = clip(rnd30(11600 * fy - 1600 * longint'(Q30)), 0, 10000);
        av = clip(rnd30(50000 * (fx - fy)), -12800, 12800);
        bv = clip(rnd30(20000 * (fy - fz)), -12800, 12800);
        e.x   = 16'(to_xyz(x, 64'hFFFF));
        e.y   = 17'(to_xyz(y, 64'h1FFFF));
        e.z   = 17'(to_xyz(z, 64'h1FFFF));
        e.lum = 14'(lv);
        e.ga  = 15'(av);
        e.by  = 15'(bv);
        pending.push_back(e);
    endfunction

    function void check_pixel(lab_px_t got);
        lab_px_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result x=%0d", $realtime, got.x);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.x !== e.x) begin
            $display("%0t: xyz_x exp %0d got %0d", $realtime, e.x, got.x); errors++;
        end
        if (got.y !== e.y) begin
            $display("%0t: xyz_y exp %0d got %0d", $realtime, e.y, got.y); errors++;
        end
        if (got.z !== e.z) begin
            $display("%0t: xyz_z exp %0d got %0d", $realtime, e.z, got.z); errors++;
        end
        if (got.lum !== e.lum) begin
            $display("%0t: lightness exp %0d got %0d", $realtime, e.lum, got.lum); errors++;
        end
        if (got.ga !== e.ga) begin
            $display("%0t: green_red exp %0d got %0d", $realtime, e.ga, got.ga); errors++;
        end
        if (got.by !== e.by) begin
            $display("%0t: blue_yellow exp %0d got %0d", $realtime, e.by, got.by); errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 75;
    localparam int CYCLE_CAP = 300000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_red = '0;
    logic [7:0]         s_green = '0;
    logic [7:0]         s_blue = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_xyz_x;
    logic [16:0]        m_xyz_y;
    logic [16:0]        m_xyz_z;
    logic [13:0]        m_lightness;
    logic signed [14:0] m_green_red;
    logic signed [14:0] m_blue_yellow;

    lab_scoreboard sb = new();
    int  cycles = 0;
    bit  src_busy = 1'b1;   // burst mode: no gaps when clear
    bit  snk_busy = 1'b1;

    srgb_to_cielab_converter_unit dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_red, .s_green, .s_blue,
        .m_valid, .m_ready, .m_xyz_x, .m_xyz_y, .m_xyz_z, .m_lightness,
        .m_green_red, .m_blue_yellow
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        lab_px_t got;
        if (aresetn && m_valid && m_ready) begin
            got.x = m_xyz_x;  got.y = m_xyz_y;  got.z = m_xyz_z;
            got.lum = m_lightness;  got.ga = m_green_red;  got.by = m_blue_yellow;
            sb.check_pixel(got);
        end
    end

    // result side back-pressure
    initial begin
        int gap;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = snk_busy ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = src_busy ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(r, g, b);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 1) ? 0 : 255);
            1: return 8'($urandom_range(8, 13));   // around the linear/power knee
            2: return 8'($urandom_range(0, 20));
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        int i;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd10, 8'd10, 8'd10);
        send_pixel(8'd11, 8'd11, 8'd11);
        send_pixel(8'd10, 8'd11, 8'd1);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd170, 8'd85, 8'd85);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd254, 8'd255, 8'd254);
        send_pixel(8'd0, 8'd255, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd1);

        for (i = 0; i < 1800; i++) begin
            if (i % 150 == 0) begin
                src_busy = $urandom_range(0, 3) != 0;
                snk_busy = $urandom_range(0, 3) != 0;
            end
            send_pixel(pick_code(), pick_code(), pick_code());
        end
        s_valid <= 1'b0;
        snk_busy = 1'b1;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire
